>>> hw/rtl/byte_stream_comparator_unit_assert.svh
// Assertion macros for the byte stream comparator unit.
// Taken in by the RTL files that carry assertions; no other dependencies.
`ifndef BYTE_STREAM_COMPARATOR_UNIT_ASSERT_SVH
`define BYTE_STREAM_COMPARATOR_UNIT_ASSERT_SVH

`ifndef SYNTH
`define BSC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bsc assertion failed");
`define BSC_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("bsc forbidden condition seen");
`else
`define BSC_ASSERT(lbl, clk, rstn, prop)
`define BSC_NEVER(lbl, clk, rstn, expr)
`endif

`endif

>>> hw/rtl/bsc_pkg.sv
// Types, constants and helper functions of the byte stream comparator unit.
// Used by bsc_step and byte_stream_comparator_unit; depends on nothing.
package bsc_pkg;

  localparam int unsigned COUNT_BITS = 48;
  localparam int unsigned GROUP_BITS = COUNT_BITS - 3;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [1:0] MODE_LIST    = 2'd1;
  localparam logic [1:0] MODE_WORD    = 2'd2;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    KIND_SAME      = 3'd0,
    KIND_DIFFERED  = 3'd1,
    KIND_FIRST     = 3'd2,
    KIND_LISTED    = 3'd3,
    KIND_END_A     = 3'd4,
    KIND_END_B     = 3'd5,
    KIND_WORD      = 3'd6
  } report_kind_e;

  typedef struct packed {
    logic       start_new;
    logic       b_present;
    logic       a_present;
    logic [7:0] byte_b;
    logic [7:0] byte_a;
  } bsc_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] byte_count;
    logic [COUNT_BITS-1:0] line_count;
    logic                  stopped;
    logic                  any_difference;
    logic [63:0]           group_a;
    logic [63:0]           group_b;
    logic [3:0]            group_fill;
    logic                  group_differs;
  } bsc_state_t;

  typedef struct packed {
    report_kind_e          report_kind;
    logic [COUNT_BITS-1:0] position;
    logic [COUNT_BITS-1:0] line_number;
    logic [7:0]            diff_byte_a;
    logic [7:0]            diff_byte_b;
    logic [63:0]           word_a;
    logic [63:0]           word_b;
    logic [3:0]            word_bytes;
    logic [GROUP_BITS-1:0] group_number;
    logic                  last_of_run;
  } bsc_result_t;

  localparam bsc_state_t RUN_RESET = '{
    byte_count:     '0,
    line_count:     COUNT_BITS'(1),
    stopped:        1'b0,
    any_difference: 1'b0,
    group_a:        '0,
    group_b:        '0,
    group_fill:     '0,
    group_differs:  1'b0
  };

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
  endfunction

  function automatic bsc_result_t word_result(input bsc_state_t st);
    bsc_result_t           r;
    logic [COUNT_BITS-1:0] fill;
    logic [COUNT_BITS-1:0] start;
    r = '0;
    fill = COUNT_BITS'(st.group_fill);
    start = (st.byte_count >= fill) ? st.byte_count - fill : '0;
    r.report_kind  = KIND_WORD;
    r.word_a       = st.group_a;
    r.word_b       = st.group_b;
    r.word_bytes   = st.group_fill;
    r.group_number = start[COUNT_BITS-1:3];
    return r;
  endfunction

endpackage

>>> hw/rtl/bsc_step.sv
// Next-state and result logic for one byte pair of the comparator.
// Depends on bsc_pkg.
module bsc_step import bsc_pkg::*; (
  input  logic [1:0]  mode_i,
  input  bsc_state_t  state_i,
  input  bsc_item_t   item_i,
  output bsc_state_t  state_o,
  output bsc_result_t res0_o,
  output bsc_result_t res1_o,
  output logic [1:0]  count_o
);

  bsc_state_t            s;
  bsc_state_t            nxt;
  bsc_result_t           r0;
  bsc_result_t           r1;
  logic [1:0]            n;
  logic                  word_mode;
  logic                  list_mode;
  logic [2:0]            slot;
  logic [5:0]            shamt;
  logic [COUNT_BITS-1:0] bc_inc;

  always_comb begin
    s         = item_i.start_new ? RUN_RESET : state_i;
    nxt       = s;
    r0        = '0;
    r1        = '0;
    n         = 2'd0;
    word_mode = (mode_i == MODE_WORD);
    list_mode = (mode_i == MODE_LIST);
    slot      = s.group_fill[2:0];
    shamt     = {3'd7 - slot, 3'b000};
    bc_inc    = sat_inc(s.byte_count);

    if (!s.stopped) begin
      if (item_i.a_present && item_i.b_present) begin
        nxt.byte_count = bc_inc;
        if (item_i.byte_a == item_i.byte_b && item_i.byte_a == NEWLINE_BYTE) begin
          nxt.line_count = sat_inc(s.line_count);
        end
        if (word_mode) begin
          nxt.group_a       = s.group_a | (64'(item_i.byte_a) << shamt);
          nxt.group_b       = s.group_b | (64'(item_i.byte_b) << shamt);
          nxt.group_fill    = {1'b0, slot} + 4'd1;
          nxt.group_differs = s.group_differs | (item_i.byte_a != item_i.byte_b);
          if (slot == 3'd7) begin
            if (nxt.group_differs) begin
              nxt.any_difference = 1'b1;
              r0 = word_result(nxt);
              n  = 2'd1;
            end
            nxt.group_a       = '0;
            nxt.group_b       = '0;
            nxt.group_fill    = '0;
            nxt.group_differs = 1'b0;
          end
        end else if (item_i.byte_a != item_i.byte_b) begin
          nxt.any_difference = 1'b1;
          r0.position    = bc_inc;
          r0.diff_byte_a = item_i.byte_a;
          r0.diff_byte_b = item_i.byte_b;
          n = 2'd1;
          if (list_mode) begin
            r0.report_kind = KIND_LISTED;
          end else begin
            r0.report_kind = KIND_FIRST;
            r0.line_number = nxt.line_count;
            nxt.stopped    = 1'b1;
          end
        end
      end else if (item_i.a_present != item_i.b_present) begin
        nxt.any_difference = 1'b1;
        nxt.stopped        = 1'b1;
        if (word_mode) begin
          r0 = word_result(s);
          r1.report_kind = item_i.a_present ? KIND_END_B : KIND_END_A;
          r1.position    = bc_inc;
          n = 2'd2;
          nxt.group_a       = '0;
          nxt.group_b       = '0;
          nxt.group_fill    = '0;
          nxt.group_differs = 1'b0;
        end else begin
          r0.report_kind = item_i.a_present ? KIND_END_B : KIND_END_A;
          r0.position    = bc_inc;
          n = 2'd1;
        end
      end else begin
        nxt.stopped = 1'b1;
        if (word_mode && s.group_fill != 4'd0 && s.group_differs) begin
          nxt.any_difference = 1'b1;
          r0 = word_result(s);
          r1.report_kind = KIND_DIFFERED;
          r1.position    = s.byte_count;
          n = 2'd2;
        end else begin
          r0.report_kind = s.any_difference ? KIND_DIFFERED : KIND_SAME;
          r0.position    = s.byte_count;
          n = 2'd1;
        end
        if (word_mode) begin
          nxt.group_a       = '0;
          nxt.group_b       = '0;
          nxt.group_fill    = '0;
          nxt.group_differs = 1'b0;
        end
      end
    end

    if (n == 2'd1) begin
      r0.last_of_run = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last_of_run = 1'b1;
    end

    state_o = nxt;
    res0_o  = r0;
    res1_o  = r1;
    count_o = n;
  end

endmodule

>>> hw/rtl/byte_stream_comparator_unit.sv
// Top level of the byte stream comparator: input register, run state,
// result registers and the mode register. Depends on bsc_pkg and bsc_step.
//
//  Channel   Dir  Handshake                    Payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: byte pair, present flags, start_new
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: report fields, tuser: kind, tlast
//  cfg       in   cfg_valid_i/cfg_ready_o      compare_mode
//
// An item goes from the input register through the compare logic into the
// result registers, so a report is valid on the output once its item moves on
// from the input register, and it can leave when the output is ready.
// One item per cycle is sustained while the output is ready; an item that
// yields two reports holds the compare stage while the second report drains.
// Reset clears the mode to zero and starts a fresh comparison run.
// A stalled output holds its report and backs up into the input side.
module byte_stream_comparator_unit import bsc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // byte_a, byte_b, a_present, b_present, start_new, zero fill
  input  logic [23:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // position, line_number, diff_byte_a, diff_byte_b, word_a, word_b,
  // word_bytes, group_number, zero fill
  output logic [295:0] m_axis_tdata,
  // report_kind
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_data_i
);

`include "byte_stream_comparator_unit_assert.svh"

  logic [1:0]  mode_q;
  logic        in_valid_q;
  bsc_item_t   in_q;
  bsc_state_t  state_q;
  bsc_state_t  state_d;
  logic        out0_valid_q;
  logic        out1_valid_q;
  bsc_result_t out0_q;
  bsc_result_t out1_q;
  bsc_result_t res0;
  bsc_result_t res1;
  logic [1:0]  res_count;
  logic        pop;
  logic        commit;

  bsc_step u_step (
    .mode_i  (mode_q),
    .state_i (state_q),
    .item_i  (in_q),
    .state_o (state_d),
    .res0_o  (res0),
    .res1_o  (res1),
    .count_o (res_count)
  );

  assign pop           = out0_valid_q && m_axis_tready;
  assign commit        = in_valid_q && (!out0_valid_q || (pop && !out1_valid_q));
  assign s_axis_tready = !in_valid_q || commit;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= bsc_item_t'(s_axis_tdata[18:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RUN_RESET;
    end else if (commit) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out0_valid_q <= 1'b0;
      out1_valid_q <= 1'b0;
    end else if (commit) begin
      out0_valid_q <= (res_count != 2'd0);
      out1_valid_q <= (res_count == 2'd2);
    end else if (pop) begin
      out0_valid_q <= out1_valid_q;
      out1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out0_q <= res0;
      out1_q <= res1;
    end else if (pop) begin
      out0_q <= out1_q;
    end
  end

  assign m_axis_tvalid = out0_valid_q;
  assign m_axis_tuser  = out0_q.report_kind;
  assign m_axis_tlast  = out0_q.last_of_run;
  assign m_axis_tdata  = {7'b0, out0_q.group_number, out0_q.word_bytes,
                          out0_q.word_b, out0_q.word_a,
                          out0_q.diff_byte_b, out0_q.diff_byte_a,
                          out0_q.line_number, out0_q.position};

  `BSC_ASSERT(a_second_needs_first, clk_i, rst_ni, out1_valid_q |-> out0_valid_q)
  `BSC_ASSERT(a_pair_last_order, clk_i, rst_ni,
    out1_valid_q |-> (out1_q.last_of_run && !out0_q.last_of_run))
  `BSC_NEVER(a_group_fill_range, clk_i, rst_ni, state_q.group_fill > 4'd7)
  `BSC_ASSERT(a_lines_vs_bytes, clk_i, rst_ni,
    ({1'b0, state_q.line_count} <= {1'b0, state_q.byte_count} + (COUNT_BITS + 1)'(1)))

endmodule
